>>> hw/rtl/cpm_pkg.sv
`default_nettype none

package cpm_pkg;

    // Ring depth default and fixed field widths
    localparam int RING_DEPTH_DEF = 8;
    localparam int CAP_W          = 16;
    localparam int PERIOD_W       = 32;
    localparam int SLOT_OUT_W     = 3;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    // Register reset values
    localparam logic [15:0] TIMER_MODULO_RST   = 16'hFFFF;
    localparam logic [2:0]  PRESCALE_SHIFT_RST = 3'd7;
    localparam logic [7:0]  EDGES_PER_REV_RST  = 8'd6;

    // Overflow counter saturation limit
    localparam logic [15:0] OVF_MAX = 16'hFFFF;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_MODULO   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGES_PER_REV  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_SCALE,
        ST_READ,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // take the input item, update counters
        logic sum_en;    // diff plus overflow ticks
        logic ring_wr;   // scale and store in ring
        logic ring_rd;   // read back stored slot
        logic emit;      // load output register, advance slot
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic capture;   // current input item carries a capture
        logic out_free;  // output register can take a new result
    } t_status;

endpackage

`default_nettype wire

>>> hw/rtl/cpm_ram.sv
`default_nettype none

module cpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cpm_ctrl.sv
`default_nettype none

module cpm_ctrl
    import cpm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output logic         o_in_stall,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_status.capture) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.ring_wr = 1'b1;
                n_state       = ST_READ;
            end
            ST_READ: begin
                o_cmd.ring_rd = 1'b1;
                n_state       = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the previous result has been transferred
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/cpm_datapath.sv
`default_nettype none

module cpm_datapath
    import cpm_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    input  wire logic                  i_overflow_seen,
    input  wire logic                  i_capture_seen,
    input  wire logic [CAP_W-1:0]      i_capture_value,
    input  wire logic                  i_cfg_wr,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_out_stall,
    output logic                       o_out_valid,
    output logic [PERIOD_W-1:0]        o_revolution_period,
    output logic [SLOT_OUT_W-1:0]      o_slot_index
);

    localparam int SLOT_W = $clog2(RING_DEPTH);

    logic [15:0]         r_timer_modulo;
    logic [2:0]          r_prescale_shift;
    logic [7:0]          r_edges_per_rev;

    logic [CAP_W-1:0]    r_last_capture;
    logic [15:0]         r_overflow_count;
    logic [SLOT_W-1:0]   r_write_slot;

    logic [CAP_W-1:0]    r_diff;
    logic [15:0]         r_factor;
    logic [PERIOD_W-1:0] r_sum;

    logic                r_out_valid;
    logic [PERIOD_W-1:0] r_out_period;
    logic [SLOT_W-1:0]   r_out_slot;

    logic [15:0]         ovf_next;
    logic [16:0]         tick_period;
    logic [32:0]         ovf_ticks;
    logic [PERIOD_W-1:0] shifted;
    logic [39:0]         scaled;
    logic [PERIOD_W-1:0] ring_rd_data;
    logic [SLOT_W+2:0]   slot_ext;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_modulo   <= TIMER_MODULO_RST;
            r_prescale_shift <= PRESCALE_SHIFT_RST;
            r_edges_per_rev  <= EDGES_PER_REV_RST;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                CFG_TIMER_MODULO:   r_timer_modulo   <= i_cfg_data;
                CFG_PRESCALE_SHIFT: r_prescale_shift <= i_cfg_data[2:0];
                CFG_EDGES_PER_REV:  r_edges_per_rev  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Saturating overflow count including this item's overflow
    assign ovf_next = (i_overflow_seen && (r_overflow_count != OVF_MAX))
                    ? r_overflow_count + 16'd1 : r_overflow_count;

    // Capture state and slot pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_capture   <= '0;
            r_overflow_count <= '0;
            r_write_slot     <= '0;
        end else begin
            if (i_cmd.accept) begin
                if (i_capture_seen) begin
                    r_last_capture   <= i_capture_value;
                    r_overflow_count <= '0;
                end else begin
                    r_overflow_count <= ovf_next;
                end
            end
            if (i_cmd.emit) begin
                if (r_write_slot == SLOT_W'(RING_DEPTH - 1)) begin
                    r_write_slot <= '0;
                end else begin
                    r_write_slot <= r_write_slot + SLOT_W'(1);
                end
            end
        end
    end

    // Wrapped tick difference and count of full timer periods
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_diff   <= i_capture_value - r_last_capture;
            r_factor <= (ovf_next > 16'd1) ? ovf_next - 16'd1 : 16'd0;
        end
    end

    // Add the extra timer periods, one full period is modulo+1 ticks
    assign tick_period = {1'b0, r_timer_modulo} + 17'd1;
    assign ovf_ticks   = {16'd0, tick_period} * {17'd0, r_factor};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_en) begin
            r_sum <= {{(PERIOD_W-CAP_W){1'b0}}, r_diff} + ovf_ticks[PERIOD_W-1:0];
        end
    end

    // Prescale and revolution scaling, both wrap to 32 bits
    assign shifted = r_sum << r_prescale_shift;
    assign scaled  = {8'd0, shifted} * {32'd0, r_edges_per_rev};

    cpm_ram #(
        .WIDTH (PERIOD_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.ring_wr),
        .i_wr_addr (r_write_slot),
        .i_wr_data (scaled[PERIOD_W-1:0]),
        .i_rd_en   (i_cmd.ring_rd),
        .i_rd_addr (r_write_slot),
        .o_rd_data (ring_rd_data)
    );

    // Output register, valid clears on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_period <= ring_rd_data;
            r_out_slot   <= r_write_slot;
        end
    end

    assign slot_ext            = {3'b000, r_out_slot};
    assign o_out_valid         = r_out_valid;
    assign o_revolution_period = r_out_period;
    assign o_slot_index        = slot_ext[SLOT_OUT_W-1:0];

    assign o_status.capture  = i_capture_seen;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

endmodule

`default_nettype wire

>>> hw/rtl/capture_period_meter.sv
`default_nettype none

// Revolution period meter for one wheel sensor channel. Each input transfer
// reports a timer overflow flag and a capture flag with the 16-bit captured
// count. Overflows are counted (saturating); on a capture the block forms the
// wrapped tick difference to the previous capture, adds timer_modulo+1 ticks
// for each overflow beyond the first, shifts by prescale_shift, multiplies by
// edges_per_rev (wrapping to 32 bits), stores the result in a RING_DEPTH-entry
// ring and emits it with its slot. An item without a capture is accepted in
// the idle state and gives no result; an item with a capture stalls the
// input until its result is loaded into the output register, following the
// controller sequence: accept, overflow-tick multiply, scale multiply with
// ring write, ring read-back, output load. The load waits while a previous
// result is still stalled on the output. The output register lets the next
// item be accepted while a result waits. Config writes are always ready and
// must only be issued while the block is idle.
module capture_period_meter
    import cpm_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input items
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_overflow_seen,
    input  wire logic                  i_capture_seen,
    input  wire logic [CAP_W-1:0]      i_capture_value,
    // results
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [PERIOD_W-1:0]        o_revolution_period,
    output logic [SLOT_OUT_W-1:0]      o_slot_index,
    // config writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    cpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    cpm_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_overflow_seen     (i_overflow_seen),
        .i_capture_seen      (i_capture_seen),
        .i_capture_value     (i_capture_value),
        .i_cfg_wr            (i_cfg_valid && o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_revolution_period (o_revolution_period),
        .o_slot_index        (o_slot_index)
    );

endmodule

`default_nettype wire
